### sv/gmcp_pkg.sv
package gmcp_pkg;

    // Field widths
    localparam int PRICE_BITS     = 40;
    localparam int START_BITS     = 40;
    localparam int SUM_BITS       = 56;
    localparam int OUT_BITS       = 40;
    localparam int SAMPLE_BITS    = 24;
    localparam int DRIFT_BITS     = 32;
    localparam int VOL_BITS       = 31;
    localparam int COUNT_BITS     = 16;
    localparam int DISC_BITS      = 40;
    localparam int CFG_DATA_BITS  = 40;
    localparam int CFG_INDEX_BITS = 3;

    // Width that holds both the start price register and the price range
    localparam int LIM_BITS = (PRICE_BITS > START_BITS) ? PRICE_BITS : START_BITS;

    // Fixed point fraction positions
    localparam int SAMPLE_FRAC = 20;
    localparam int RATE_FRAC   = 28;
    localparam int DISC_FRAC   = 40;

    // Step rate: drift + sign(z) * ((vol * |z|) >> 20)
    localparam int VOLTERM_BITS = VOL_BITS + SAMPLE_BITS - SAMPLE_FRAC;
    localparam int RATE_BITS    = VOLTERM_BITS + 2;
    localparam int RMAG_BITS    = RATE_BITS - 1;
    localparam int DELTA_BITS   = PRICE_BITS + RMAG_BITS - RATE_FRAC;

    // Shared multiplier: 56-bit operand times up to three 16-bit digits
    localparam int MUL_A_BITS    = 56;
    localparam int DIGIT_BITS    = 16;
    localparam int MUL_DIGITS    = 3;
    localparam int MUL_B_BITS    = MUL_DIGITS * DIGIT_BITS;
    localparam int PROD_BITS     = MUL_A_BITS + MUL_B_BITS;
    localparam int MUL_CNT_BITS  = 2;
    localparam int VMUL_DIGITS   = 2;
    localparam int VMUL_LO_BITS  = VMUL_DIGITS * DIGIT_BITS;
    localparam int VPROD_BITS    = MUL_A_BITS + VMUL_LO_BITS;

    localparam logic [MUL_CNT_BITS-1:0] VMUL_LAST = MUL_CNT_BITS'(VMUL_DIGITS - 1);
    localparam logic [MUL_CNT_BITS-1:0] FULL_LAST = MUL_CNT_BITS'(MUL_DIGITS - 1);

    // Sequencer states
    typedef enum logic [2:0] {
        ST_IDLE,
        ST_VMUL,
        ST_PMUL,
        ST_ACC,
        ST_FMUL,
        ST_FOUT
    } t_state;

    // Configuration register indexes
    typedef enum logic [CFG_INDEX_BITS-1:0] {
        CFG_START_PRICE   = 3'd0,
        CFG_DRIFT_STEP    = 3'd1,
        CFG_VOL_STEP      = 3'd2,
        CFG_STEPS_PER_PATH = 3'd3,
        CFG_PATH_COUNT    = 3'd4,
        CFG_PATH_DISCOUNT = 3'd5
    } t_cfg_index;

    // Request to the shared multiplier
    typedef struct packed {
        logic                    start;
        logic [MUL_CNT_BITS-1:0] last_digit;
        logic [MUL_A_BITS-1:0]   a;
        logic [MUL_B_BITS-1:0]   b;
    } t_mul_req;

    // Response from the shared multiplier
    typedef struct packed {
        logic                 done;
        logic [PROD_BITS-1:0] product;
    } t_mul_rsp;

endpackage

### sv/gmcp_mul.sv
// Digit-serial multiplier: one 56x16 partial product per cycle, low digit first.
// After n digits the product is {hi, top 16*n bits of lo}.
module gmcp_mul (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  gmcp_pkg::t_mul_req  i_req,
    output gmcp_pkg::t_mul_rsp  o_rsp
);

    logic [gmcp_pkg::MUL_A_BITS-1:0]            r_a;
    logic [gmcp_pkg::MUL_B_BITS-1:0]            r_b;
    logic [gmcp_pkg::MUL_A_BITS-1:0]            r_hi;
    logic [gmcp_pkg::MUL_B_BITS-1:0]            r_lo;
    logic [gmcp_pkg::MUL_CNT_BITS-1:0]          r_cnt;
    logic                                       r_busy;
    logic                                       r_done;
    logic [gmcp_pkg::MUL_A_BITS+gmcp_pkg::DIGIT_BITS-1:0] w_pp;
    logic [gmcp_pkg::MUL_A_BITS+gmcp_pkg::DIGIT_BITS-1:0] w_acc;

    // Partial product of the current digit plus the running high part
    assign w_pp  = r_a * r_b[gmcp_pkg::DIGIT_BITS-1:0];
    assign w_acc = w_pp + (gmcp_pkg::MUL_A_BITS + gmcp_pkg::DIGIT_BITS)'(r_hi);

    // Sequence control
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
            r_cnt  <= '0;
        end else if (i_req.start) begin
            r_busy <= 1'b1;
            r_done <= 1'b0;
            r_cnt  <= i_req.last_digit;
        end else begin
            r_done <= r_busy && (r_cnt == '0);
            if (r_busy) begin
                if (r_cnt == '0) begin
                    r_busy <= 1'b0;
                end else begin
                    r_cnt <= r_cnt - gmcp_pkg::MUL_CNT_BITS'(1);
                end
            end
        end
    end

    // Operands and partial sums
    always_ff @(posedge i_clk) begin
        if (i_req.start) begin
            r_a  <= i_req.a;
            r_b  <= i_req.b;
            r_hi <= '0;
            r_lo <= '0;
        end else if (r_busy) begin
            r_hi <= w_acc[gmcp_pkg::MUL_A_BITS+gmcp_pkg::DIGIT_BITS-1:gmcp_pkg::DIGIT_BITS];
            r_lo <= {w_acc[gmcp_pkg::DIGIT_BITS-1:0],
                     r_lo[gmcp_pkg::MUL_B_BITS-1:gmcp_pkg::DIGIT_BITS]};
            r_b  <= r_b >> gmcp_pkg::DIGIT_BITS;
        end
    end

    assign o_rsp.done    = r_done;
    assign o_rsp.product = {r_hi, r_lo};

endmodule

### sv/gbm_monte_carlo_pricer.sv
// Monte Carlo pricer for geometric Brownian motion (Euler scheme, fixed point).
// Each accepted word is one standard normal sample (Q3.20); it moves the running
// path price by S += S*(drift_step + vol_step*z), saturating at zero and at the
// top of the price range. After steps_per_path samples the final price is added
// to the path sum; after path_count paths one word leaves with the sum times
// path_discount (Q0.40) and a flag that tells whether any saturation happened.
// One 56x16 multiplier, one digit per cycle, does all products: vol*|z| (2 digits),
// then price*rate (3 digits); a sample that ends a path then adds the final price
// to the path sum, and one that ends a run also forms sum*path_discount (3 digits)
// and waits for a free output register. The user must write configuration only
// while idle; the block itself does not enforce it.
module gbm_monte_carlo_pricer (
    input  logic                                    i_clk,
    input  logic                                    i_rst_n,
    input  logic                                    i_cfg_we,
    input  logic [gmcp_pkg::CFG_INDEX_BITS-1:0]     i_cfg_index,
    input  logic [gmcp_pkg::CFG_DATA_BITS-1:0]      i_cfg_data,
    input  logic                                    i_valid,
    output logic                                    o_stall,
    input  logic signed [gmcp_pkg::SAMPLE_BITS-1:0] i_normal_sample,
    output logic                                    o_valid,
    input  logic                                    i_stall,
    output logic [gmcp_pkg::OUT_BITS-1:0]           o_fair_value,
    output logic                                    o_clamped
);

    // Configuration registers
    logic [gmcp_pkg::PRICE_BITS-1:0]          w_start_fit;
    logic [gmcp_pkg::START_BITS-1:0]          r_start_price;
    logic signed [gmcp_pkg::DRIFT_BITS-1:0]   r_drift_step;
    logic [gmcp_pkg::VOL_BITS-1:0]            r_vol_step;
    logic [gmcp_pkg::COUNT_BITS-1:0]          r_steps_per_path;
    logic [gmcp_pkg::COUNT_BITS-1:0]          r_path_count;
    logic [gmcp_pkg::DISC_BITS-1:0]           r_path_discount;

    // Run state
    gmcp_pkg::t_state                         r_state;
    gmcp_pkg::t_state                         n_state;
    logic [gmcp_pkg::PRICE_BITS-1:0]          r_path_price;
    logic [gmcp_pkg::PRICE_BITS-1:0]          n_path_price;
    logic [gmcp_pkg::COUNT_BITS-1:0]          r_step_index;
    logic [gmcp_pkg::COUNT_BITS-1:0]          n_step_index;
    logic [gmcp_pkg::COUNT_BITS-1:0]          r_path_index;
    logic [gmcp_pkg::COUNT_BITS-1:0]          n_path_index;
    logic [gmcp_pkg::SUM_BITS-1:0]            r_final_sum;
    logic [gmcp_pkg::SUM_BITS-1:0]            n_final_sum;
    logic                                     r_clamp_seen;
    logic                                     n_clamp_seen;
    logic                                     r_zneg;
    logic                                     n_zneg;
    logic                                     r_rneg;
    logic                                     n_rneg;

    // Output register
    logic                                     r_out_valid;
    logic                                     n_out_valid;
    logic [gmcp_pkg::OUT_BITS-1:0]            r_out_fair_value;
    logic [gmcp_pkg::OUT_BITS-1:0]            n_out_fair_value;
    logic                                     r_out_clamped;
    logic                                     n_out_clamped;

    // Multiplier link
    gmcp_pkg::t_mul_req                       w_req;
    gmcp_pkg::t_mul_rsp                       w_rsp;

    // Datapath terms
    logic                                     w_in_accept;
    logic                                     w_out_free;
    logic [gmcp_pkg::SAMPLE_BITS-1:0]         w_z;
    logic [gmcp_pkg::SAMPLE_BITS-1:0]         w_zmag;
    logic [gmcp_pkg::VPROD_BITS-1:0]          w_vprod;
    logic [gmcp_pkg::VOLTERM_BITS-1:0]        w_volterm;
    logic signed [gmcp_pkg::RATE_BITS-1:0]    w_rate;
    logic [gmcp_pkg::RATE_BITS-1:0]           w_rate_neg;
    logic [gmcp_pkg::RMAG_BITS-1:0]           w_rmag;
    logic [gmcp_pkg::PRICE_BITS-1:0]          w_start_lim;
    logic [gmcp_pkg::PRICE_BITS-1:0]          w_s_cur;
    logic [gmcp_pkg::DELTA_BITS-1:0]          w_delta;
    logic [gmcp_pkg::DELTA_BITS:0]            w_up;
    logic                                     w_up_ovf;
    logic                                     w_dn_ovf;
    logic [gmcp_pkg::PRICE_BITS-1:0]          w_dn;
    logic [gmcp_pkg::PRICE_BITS-1:0]          w_new_price;
    logic                                     w_price_clamp;
    logic [gmcp_pkg::COUNT_BITS-1:0]          w_steps_eff;
    logic [gmcp_pkg::COUNT_BITS-1:0]          w_paths_eff;
    logic [gmcp_pkg::COUNT_BITS-1:0]          w_step_next;
    logic [gmcp_pkg::COUNT_BITS-1:0]          w_path_next;
    logic                                     w_path_end;
    logic                                     w_run_end;
    logic [gmcp_pkg::SUM_BITS:0]              w_sum_full;
    logic [gmcp_pkg::SUM_BITS-1:0]            w_sum_sat;
    logic [gmcp_pkg::SUM_BITS-1:0]            w_fv;
    logic                                     w_fv_ovf;

    gmcp_mul u_mul (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_req   (w_req),
        .o_rsp   (w_rsp)
    );

    assign w_in_accept = i_valid && (r_state == gmcp_pkg::ST_IDLE);
    assign w_out_free  = !r_out_valid || !i_stall;

    // Sample magnitude and sign
    assign w_z    = i_normal_sample;
    assign w_zmag = w_z[gmcp_pkg::SAMPLE_BITS-1] ? (~w_z + gmcp_pkg::SAMPLE_BITS'(1)) : w_z;

    // Two-digit product sits in hi and the upper part of lo
    assign w_vprod   = {w_rsp.product[gmcp_pkg::PROD_BITS-1:gmcp_pkg::MUL_B_BITS],
                        w_rsp.product[gmcp_pkg::MUL_B_BITS-1:
                                      gmcp_pkg::MUL_B_BITS-gmcp_pkg::VMUL_LO_BITS]};
    assign w_volterm = w_vprod[gmcp_pkg::SAMPLE_FRAC +: gmcp_pkg::VOLTERM_BITS];

    // Step rate and its magnitude
    assign w_rate = r_zneg
        ? gmcp_pkg::RATE_BITS'(r_drift_step)
          - signed'(gmcp_pkg::RATE_BITS'(w_volterm))
        : gmcp_pkg::RATE_BITS'(r_drift_step)
          + signed'(gmcp_pkg::RATE_BITS'(w_volterm));
    assign w_rate_neg = -w_rate;
    assign w_rmag = w_rate[gmcp_pkg::RATE_BITS-1]
        ? w_rate_neg[gmcp_pkg::RMAG_BITS-1:0]
        : w_rate[gmcp_pkg::RMAG_BITS-1:0];

    // Price at the head of a step: start price on the first step of a path
    assign w_start_fit = gmcp_pkg::PRICE_BITS'(r_start_price);
    assign w_start_lim = (gmcp_pkg::LIM_BITS'(r_start_price)
                          > gmcp_pkg::LIM_BITS'({gmcp_pkg::PRICE_BITS{1'b1}}))
        ? {gmcp_pkg::PRICE_BITS{1'b1}} : w_start_fit;
    assign w_s_cur = (r_step_index == '0) ? w_start_lim : r_path_price;

    // Price update with saturation at zero and at the top
    assign w_delta  = w_rsp.product[gmcp_pkg::RATE_FRAC +: gmcp_pkg::DELTA_BITS];
    assign w_up     = (gmcp_pkg::DELTA_BITS+1)'(r_path_price)
                    + (gmcp_pkg::DELTA_BITS+1)'(w_delta);
    assign w_up_ovf = w_up > (gmcp_pkg::DELTA_BITS+1)'({gmcp_pkg::PRICE_BITS{1'b1}});
    assign w_dn_ovf = w_delta > gmcp_pkg::DELTA_BITS'(r_path_price);
    assign w_dn     = r_path_price - gmcp_pkg::PRICE_BITS'(w_delta);

    always_comb begin
        if (r_rneg) begin
            w_new_price   = w_dn_ovf ? '0 : w_dn;
            w_price_clamp = w_dn_ovf;
        end else begin
            w_new_price   = w_up_ovf ? {gmcp_pkg::PRICE_BITS{1'b1}}
                                     : gmcp_pkg::PRICE_BITS'(w_up);
            w_price_clamp = w_up_ovf;
        end
    end

    // Step and path counters; a zero count acts as one
    assign w_steps_eff = (r_steps_per_path == '0) ? gmcp_pkg::COUNT_BITS'(1) : r_steps_per_path;
    assign w_paths_eff = (r_path_count == '0) ? gmcp_pkg::COUNT_BITS'(1) : r_path_count;
    assign w_step_next = r_step_index + gmcp_pkg::COUNT_BITS'(1);
    assign w_path_next = r_path_index + gmcp_pkg::COUNT_BITS'(1);
    assign w_path_end  = (w_step_next == '0) || (w_step_next >= w_steps_eff);
    assign w_run_end   = (w_path_next == '0) || (w_path_next >= w_paths_eff);

    // Path sum with saturation
    assign w_sum_full = (gmcp_pkg::SUM_BITS+1)'(r_final_sum)
                      + (gmcp_pkg::SUM_BITS+1)'(r_path_price);
    assign w_sum_sat  = w_sum_full[gmcp_pkg::SUM_BITS] ? {gmcp_pkg::SUM_BITS{1'b1}}
                                                       : w_sum_full[gmcp_pkg::SUM_BITS-1:0];

    // Discounted result
    assign w_fv     = w_rsp.product[gmcp_pkg::DISC_FRAC +: gmcp_pkg::SUM_BITS];
    assign w_fv_ovf = |w_fv[gmcp_pkg::SUM_BITS-1:gmcp_pkg::OUT_BITS];

    // Next state
    always_comb begin
        n_state = r_state;
        unique case (r_state)
            gmcp_pkg::ST_IDLE: begin
                if (i_valid) begin
                    n_state = gmcp_pkg::ST_VMUL;
                end
            end
            gmcp_pkg::ST_VMUL: begin
                if (w_rsp.done) begin
                    n_state = gmcp_pkg::ST_PMUL;
                end
            end
            gmcp_pkg::ST_PMUL: begin
                if (w_rsp.done) begin
                    n_state = w_path_end ? gmcp_pkg::ST_ACC : gmcp_pkg::ST_IDLE;
                end
            end
            gmcp_pkg::ST_ACC: begin
                n_state = w_run_end ? gmcp_pkg::ST_FMUL : gmcp_pkg::ST_IDLE;
            end
            gmcp_pkg::ST_FMUL: begin
                if (w_rsp.done) begin
                    n_state = gmcp_pkg::ST_FOUT;
                end
            end
            gmcp_pkg::ST_FOUT: begin
                if (w_out_free) begin
                    n_state = gmcp_pkg::ST_IDLE;
                end
            end
            default: n_state = gmcp_pkg::ST_IDLE;
        endcase
    end

    // Datapath control and next values
    always_comb begin
        w_req            = '0;
        n_path_price     = r_path_price;
        n_step_index     = r_step_index;
        n_path_index     = r_path_index;
        n_final_sum      = r_final_sum;
        n_clamp_seen     = r_clamp_seen;
        n_zneg           = r_zneg;
        n_rneg           = r_rneg;
        n_out_fair_value = r_out_fair_value;
        n_out_clamped    = r_out_clamped;
        n_out_valid      = r_out_valid && i_stall;

        unique case (r_state)
            gmcp_pkg::ST_IDLE: begin
                // Start vol_step * |z|
                if (w_in_accept) begin
                    n_zneg           = w_z[gmcp_pkg::SAMPLE_BITS-1];
                    w_req.start      = 1'b1;
                    w_req.last_digit = gmcp_pkg::VMUL_LAST;
                    w_req.a          = gmcp_pkg::MUL_A_BITS'(r_vol_step);
                    w_req.b          = gmcp_pkg::MUL_B_BITS'(w_zmag);
                end
            end
            gmcp_pkg::ST_VMUL: begin
                // Form the rate and start price * |rate|
                if (w_rsp.done) begin
                    n_path_price     = w_s_cur;
                    n_rneg           = w_rate[gmcp_pkg::RATE_BITS-1];
                    w_req.start      = 1'b1;
                    w_req.last_digit = gmcp_pkg::FULL_LAST;
                    w_req.a          = gmcp_pkg::MUL_A_BITS'(w_s_cur);
                    w_req.b          = gmcp_pkg::MUL_B_BITS'(w_rmag);
                end
            end
            gmcp_pkg::ST_PMUL: begin
                // Apply the step and advance the step counter
                if (w_rsp.done) begin
                    n_path_price = w_new_price;
                    n_clamp_seen = r_clamp_seen | w_price_clamp;
                    n_step_index = w_path_end ? '0 : w_step_next;
                end
            end
            gmcp_pkg::ST_ACC: begin
                // Add the final price; at run end start sum * discount
                n_clamp_seen = r_clamp_seen | w_sum_full[gmcp_pkg::SUM_BITS];
                if (w_run_end) begin
                    n_final_sum      = '0;
                    n_path_index     = '0;
                    w_req.start      = 1'b1;
                    w_req.last_digit = gmcp_pkg::FULL_LAST;
                    w_req.a          = gmcp_pkg::MUL_A_BITS'(w_sum_sat);
                    w_req.b          = gmcp_pkg::MUL_B_BITS'(r_path_discount);
                end else begin
                    n_final_sum  = w_sum_sat;
                    n_path_index = w_path_next;
                end
            end
            gmcp_pkg::ST_FMUL: begin
                // Wait for the discount product
            end
            gmcp_pkg::ST_FOUT: begin
                // Load the output word once the register is free
                if (w_out_free) begin
                    n_out_valid      = 1'b1;
                    n_out_fair_value = w_fv_ovf ? {gmcp_pkg::OUT_BITS{1'b1}}
                                                : w_fv[gmcp_pkg::OUT_BITS-1:0];
                    n_out_clamped    = r_clamp_seen | w_fv_ovf;
                    n_clamp_seen     = 1'b0;
                end
            end
            default: begin
            end
        endcase
    end

    // Configuration writes
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_start_price    <= '0;
            r_drift_step     <= '0;
            r_vol_step       <= '0;
            r_steps_per_path <= gmcp_pkg::COUNT_BITS'(1);
            r_path_count     <= gmcp_pkg::COUNT_BITS'(1);
            r_path_discount  <= '0;
        end else if (i_cfg_we) begin
            unique case (gmcp_pkg::t_cfg_index'(i_cfg_index))
                gmcp_pkg::CFG_START_PRICE:    r_start_price    <=
                    i_cfg_data[gmcp_pkg::START_BITS-1:0];
                gmcp_pkg::CFG_DRIFT_STEP:     r_drift_step     <=
                    i_cfg_data[gmcp_pkg::DRIFT_BITS-1:0];
                gmcp_pkg::CFG_VOL_STEP:       r_vol_step       <=
                    i_cfg_data[gmcp_pkg::VOL_BITS-1:0];
                gmcp_pkg::CFG_STEPS_PER_PATH: r_steps_per_path <=
                    i_cfg_data[gmcp_pkg::COUNT_BITS-1:0];
                gmcp_pkg::CFG_PATH_COUNT:     r_path_count     <=
                    i_cfg_data[gmcp_pkg::COUNT_BITS-1:0];
                gmcp_pkg::CFG_PATH_DISCOUNT:  r_path_discount  <=
                    i_cfg_data[gmcp_pkg::DISC_BITS-1:0];
                default: begin
                end
            endcase
        end
    end

    // Control and run state
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state      <= gmcp_pkg::ST_IDLE;
            r_step_index <= '0;
            r_path_index <= '0;
            r_final_sum  <= '0;
            r_clamp_seen <= 1'b0;
            r_out_valid  <= 1'b0;
        end else begin
            r_state      <= n_state;
            r_step_index <= n_step_index;
            r_path_index <= n_path_index;
            r_final_sum  <= n_final_sum;
            r_clamp_seen <= n_clamp_seen;
            r_out_valid  <= n_out_valid;
        end
    end

    // Payload registers
    always_ff @(posedge i_clk) begin
        r_path_price     <= n_path_price;
        r_zneg           <= n_zneg;
        r_rneg           <= n_rneg;
        r_out_fair_value <= n_out_fair_value;
        r_out_clamped    <= n_out_clamped;
    end

    assign o_stall      = (r_state != gmcp_pkg::ST_IDLE);
    assign o_valid      = r_out_valid;
    assign o_fair_value = r_out_fair_value;
    assign o_clamped    = r_out_clamped;

endmodule
